/* sv/wpd_pkg.sv */
`default_nettype none

package wpd_pkg;

  // Pool size and field widths.
  localparam int unsigned MaxWorkers = 16;
  localparam int unsigned RankW      = $clog2(MaxWorkers);
  localparam int unsigned RanksW     = $clog2(MaxWorkers + 1);
  localparam int unsigned BoundW     = 16;
  localparam int unsigned NodeW      = 48;
  localparam int unsigned FreeW      = 5;

  // Configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WorkerCountW = 5;
  localparam logic [WorkerCountW-1:0] WorkerCountReset = WorkerCountW'(16);
  localparam logic [CfgAddrW-3:0] RegWorkerCount = '0;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_IDLE    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_BOUND   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // Input item.
  typedef struct packed {
    cmd_e              cmd;
    logic [RankW-1:0]  source_rank;
    logic [RankW-1:0]  request_count;
    logic [BoundW-1:0] bound_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [RankW-1:0]  worker_id;
    logic [RankW-1:0]  granted_count;
    logic [BoundW-1:0] best_bound;
    logic              all_free;
    logic [NodeW-1:0]  node_count;
    logic              last;
  } out_item_t;

  // Kind of result loaded into the output register.
  typedef enum logic [1:0] {
    OUT_STATUS,
    OUT_GRANT,
    OUT_CLOSE
  } out_sel_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_GRANT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     grant;
    logic     out_load;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic grant_avail;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/wpd_ctrl.sv */
`default_nettype none

module wpd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wpd_pkg::cmd_e           in_cmd_i,
  output logic                    in_stall_o,
  input  wpd_pkg::dp_status_t     status_i,
  output wpd_pkg::ctrl_cmd_t      cmd_o
);
  import wpd_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.load     = 1'b0;
    cmd_o.grant    = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.out_sel  = OUT_STATUS;
    in_stall_o     = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_IDLE, CMD_BOUND: begin
              cmd_o.load = 1'b1;
              state_d    = ST_REPLY;
            end
            CMD_REQUEST: begin
              cmd_o.load = 1'b1;
              state_d    = ST_GRANT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_REPLY: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_STATUS;
          state_d        = ST_IDLE;
        end
      end
      ST_GRANT: begin
        // One grant per cycle while out_free, then the closing result.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.grant_avail) begin
            cmd_o.grant   = 1'b1;
            cmd_o.out_sel = OUT_GRANT;
          end else begin
            cmd_o.out_sel = OUT_CLOSE;
            state_d       = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/wpd_datapath.sv */
`default_nettype none

module wpd_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wpd_pkg::ctrl_cmd_t               cmd_i,
  output wpd_pkg::dp_status_t              status_o,
  input  wpd_pkg::in_item_t                in_data_i,
  input  wire logic [wpd_pkg::RanksW-1:0]  ranks_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output wpd_pkg::out_item_t               out_data_o
);
  import wpd_pkg::*;

  logic [MaxWorkers-1:0] busy_q, busy_d;
  logic [FreeW-1:0]      free_total_q, free_total_d;
  logic [BoundW-1:0]     best_q, best_d;
  logic [NodeW-1:0]      nodes_q, nodes_d;
  logic [RankW-1:0]      limit_q, limit_d;
  logic [RankW-1:0]      granted_q, granted_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic [MaxWorkers-1:0] range_mask;
  logic [MaxWorkers-1:0] free_mask;
  logic                  found;
  logic [RankW-1:0]      first_free;
  logic                  all_free;
  logic [FreeW-1:0]      want_ext;

  // Ranks in use are 1 up to the configured count minus one.
  always_comb begin
    for (int r = 0; r < MaxWorkers; r++) begin
      range_mask[r] = (r != 0) && (RanksW'(r) < ranks_i);
    end
  end

  assign free_mask = ~busy_q & range_mask;
  assign all_free  = ((busy_q & range_mask) == '0);

  // Lowest free rank in use.
  always_comb begin
    found      = 1'b0;
    first_free = '0;
    for (int r = MaxWorkers - 1; r >= 1; r--) begin
      if (free_mask[r]) begin
        found      = 1'b1;
        first_free = RankW'(r);
      end
    end
  end

  assign want_ext             = FreeW'(in_data_i.request_count);
  assign status_o.grant_avail = found && (granted_q < limit_q);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // Pool state updates on accepted items and on grants.
  always_comb begin
    busy_d       = busy_q;
    free_total_d = free_total_q;
    best_d       = best_q;
    nodes_d      = nodes_q;
    limit_d      = limit_q;
    granted_d    = granted_q;
    if (cmd_i.load) begin
      case (in_data_i.cmd)
        CMD_IDLE: begin
          if (range_mask[in_data_i.source_rank] && busy_q[in_data_i.source_rank]) begin
            busy_d[in_data_i.source_rank] = 1'b0;
            free_total_d = free_total_q + FreeW'(1);
          end
        end
        CMD_REQUEST: begin
          nodes_d   = nodes_q + NodeW'(2);
          granted_d = '0;
          limit_d   = (want_ext < free_total_q) ? in_data_i.request_count
                                                : free_total_q[RankW-1:0];
        end
        CMD_BOUND: begin
          if (in_data_i.bound_value > best_q) begin
            best_d = in_data_i.bound_value;
          end
        end
        default: begin
          best_d = best_q;
        end
      endcase
    end
    if (cmd_i.grant) begin
      busy_d[first_free] = 1'b1;
      free_total_d       = free_total_q - FreeW'(1);
      granted_d          = granted_q + RankW'(1);
    end
  end

  // Result formatting for the output register.
  always_comb begin
    out_d               = out_q;
    out_d.worker_id     = '0;
    out_d.granted_count = '0;
    out_d.best_bound    = best_q;
    out_d.all_free      = all_free;
    out_d.node_count    = nodes_q;
    out_d.last          = 1'b1;
    case (cmd_i.out_sel)
      OUT_GRANT: begin
        // The granted rank turns busy, so the pool is not all free.
        out_d.worker_id = first_free;
        out_d.all_free  = 1'b0;
        out_d.last      = 1'b0;
      end
      OUT_CLOSE: begin
        out_d.granted_count = granted_q;
      end
      default: begin
        out_d.last = 1'b1;
      end
    endcase
  end

  // Output register: holds a result until the receiver takes the transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= '1;
      free_total_q <= '0;
      best_q       <= BoundW'(1);
      nodes_q      <= NodeW'(1);
      limit_q      <= '0;
      granted_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      free_total_q <= free_total_d;
      best_q       <= best_d;
      nodes_q      <= nodes_d;
      limit_q      <= limit_d;
      granted_q    <= granted_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* sv/worker_pool_dispatcher_core.sv */
// Worker pool dispatcher: tracks which worker ranks are free and hands them out.
// Input channel (in_valid_i, in_stall_o, in_data_i) takes one command per
// transfer: worker idle, request for free workers, or a new lower bound.
// Output channel (out_valid_o, out_stall_i, out_data_o) returns results; the
// final result of each item has last set.
// Idle and bound items give one result, loaded from the reply state when the
// output register is free. A request that grants g workers gives g + 1 results,
// one per cycle while the output register is free; a priority encoder finds the
// free rank, one grant per cycle while the output register is free. Unused
// command code 3 is dropped in the acceptance cycle with no result. One item is
// worked on at a time: in_stall_o is high until its last result is loaded into
// the output register. When the receiver stalls, the output register holds its
// result and the sequencer waits; no result is lost or repeated. Reset marks
// every worker busy, clears the free count, sets the best bound and node counter
// to one and worker_count to 16. worker_count sits at byte address 0 of the
// register port and is to be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module worker_pool_dispatcher_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wpd_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output wpd_pkg::out_item_t                   out_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wpd_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [wpd_pkg::CfgDataW-1:0]    pwdata,
  output logic [wpd_pkg::CfgDataW-1:0]         prdata,
  output logic                                 pready
);
  import wpd_pkg::*;

  logic [WorkerCountW-1:0] worker_count_q, worker_count_d;
  logic [RanksW-1:0]       ranks;
  logic                    cfg_sel;
  ctrl_cmd_t               ctrl_cmd;
  dp_status_t              dp_status;

  // Register port: a single register, word-addressed by paddr[2].
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CfgAddrW-1:2] == RegWorkerCount);

  always_comb begin
    worker_count_d = worker_count_q;
    if (psel && penable && pwrite && pready && cfg_sel) begin
      worker_count_d = pwdata[WorkerCountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= WorkerCountReset;
    end else begin
      worker_count_q <= worker_count_d;
    end
  end

  assign prdata = cfg_sel ? CfgDataW'(worker_count_q) : '0;

  // Ranks in use: worker_count limited to the range 2 to MaxWorkers.
  always_comb begin
    if (worker_count_q < WorkerCountW'(2)) begin
      ranks = RanksW'(2);
    end else if (worker_count_q > WorkerCountW'(MaxWorkers)) begin
      ranks = RanksW'(MaxWorkers);
    end else begin
      ranks = RanksW'(worker_count_q);
    end
  end

  wpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  wpd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .in_data_i   (in_data_i),
    .ranks_i     (ranks),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
